### hw/rtl/med5pf_pkg.sv
// ----------------------------------------------------------------------------
// med5pf_pkg
// shared types, constants and register codes of the five-tap median
// position filter
// ----------------------------------------------------------------------------
`default_nettype none

package med5pf_pkg;

  localparam int SampleBits      = 24;
  localparam int NumAxes         = 3;
  localparam int Window          = 5;
  localparam int QueueDepth      = 2;
  localparam int CenterLimitBits = 23;
  localparam int MissingTolBits  = 8;
  localparam int CfgDataBits     = 23;

  typedef logic signed [SampleBits-1:0] sample_t;

  // -1.0 in Q15.8 marks no detection
  localparam sample_t Missing = sample_t'(-256);

  localparam logic [CenterLimitBits-1:0] CenterLimitReset = CenterLimitBits'(25600);
  localparam logic [MissingTolBits-1:0]  MissingTolReset  = MissingTolBits'(2);

  typedef enum logic [0:0] {
    CfgCenterLimit = 1'b0,
    CfgMissingTol  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ActClimb    = 2'd0,
    ActDescend  = 2'd1,
    ActSideways = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    SrcNone  = 2'd0,
    SrcSmart = 2'd1,
    SrcLocal = 2'd2
  } source_e;

  typedef struct packed {
    sample_t smart_x;
    sample_t smart_y;
    sample_t smart_z;
    sample_t local_x;
    sample_t local_y;
    sample_t local_z;
  } in_item_t;

  typedef struct packed {
    sample_t median_x;
    sample_t median_y;
    sample_t median_z;
    action_e action;
    source_e chosen_source;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/med5pf_front.sv
// ----------------------------------------------------------------------------
// med5pf_front
// picks the source triple, keeps the per-axis history and forms the window
// ----------------------------------------------------------------------------
`default_nettype none

module med5pf_front #(
  parameter int WINDOW = med5pf_pkg::Window
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  med5pf_pkg::in_item_t in_item_i,
  input  wire                  q_full_i,
  output logic                 in_stall_o,
  output logic                 push_o,
  output med5pf_pkg::sample_t [med5pf_pkg::NumAxes-1:0][WINDOW-1:0] win_o,
  output med5pf_pkg::source_e  source_o
);

  localparam int NumAxes = med5pf_pkg::NumAxes;

  med5pf_pkg::sample_t [NumAxes-1:0] smart;
  med5pf_pkg::sample_t [NumAxes-1:0] loc;
  med5pf_pkg::sample_t [NumAxes-1:0] chosen;
  med5pf_pkg::sample_t [NumAxes-1:0][WINDOW-2:0] hist_q;
  logic smart_none;
  logic loc_none;
  logic primed_q;

  assign smart = {in_item_i.smart_z, in_item_i.smart_y, in_item_i.smart_x};
  assign loc   = {in_item_i.local_z, in_item_i.local_y, in_item_i.local_x};

  assign smart_none = (smart[0] == med5pf_pkg::Missing) && (smart[1] == med5pf_pkg::Missing) &&
                      (smart[2] == med5pf_pkg::Missing);
  assign loc_none   = (loc[0] == med5pf_pkg::Missing) && (loc[1] == med5pf_pkg::Missing) &&
                      (loc[2] == med5pf_pkg::Missing);

  assign chosen   = smart_none ? loc : smart;
  assign source_o = !smart_none ? med5pf_pkg::SrcSmart :
                    (loc_none ? med5pf_pkg::SrcNone : med5pf_pkg::SrcLocal);

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // before the first request the new sample stands in for every slot
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_o[a][i] = primed_q ? hist_q[a][i] : chosen[a];
      end
      win_o[a][WINDOW-1] = chosen[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      for (int a = 0; a < NumAxes; a++) begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          hist_q[a][i] <= win_o[a][i+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
    end else if (push_o) begin
      primed_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/med5pf_queue.sv
// ----------------------------------------------------------------------------
// med5pf_queue
// small first-in first-out queue between the front and the sorter
// ----------------------------------------------------------------------------
`default_nettype none

module med5pf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = med5pf_pkg::QueueDepth
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire [WIDTH-1:0]  wdata_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  assign full_o  = (count_q == CntBits'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/med5pf_back.sv
// ----------------------------------------------------------------------------
// med5pf_back
// odd-even transposition sorter, one layer per stage, then action decision
// and output register
// ----------------------------------------------------------------------------
`default_nettype none

module med5pf_back #(
  parameter int WINDOW = med5pf_pkg::Window
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   head_valid_i,
  input  med5pf_pkg::sample_t [med5pf_pkg::NumAxes-1:0][WINDOW-1:0] head_win_i,
  input  med5pf_pkg::source_e   head_src_i,
  output logic                  pop_o,
  input  wire [med5pf_pkg::CenterLimitBits-1:0] center_limit_i,
  input  wire [med5pf_pkg::MissingTolBits-1:0]  missing_tol_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output med5pf_pkg::out_item_t out_item_o
);

  localparam int NumAxes = med5pf_pkg::NumAxes;
  localparam int Sb      = med5pf_pkg::SampleBits;

  typedef med5pf_pkg::sample_t [NumAxes-1:0][WINDOW-1:0] win_t;

  win_t                lay_in  [WINDOW];
  win_t                lay_out [WINDOW];
  win_t                sort_q  [WINDOW];
  med5pf_pkg::source_e src_q   [WINDOW];
  logic [WINDOW-1:0]   vld_q;
  logic                adv;
  logic                out_valid_q;
  med5pf_pkg::out_item_t out_item_q, out_item_d;
  med5pf_pkg::sample_t [NumAxes-1:0] med;
  logic                all_missing;
  logic                centered;

  function automatic logic near_missing(med5pf_pkg::sample_t m,
                                        logic [med5pf_pkg::MissingTolBits-1:0] tol);
    logic signed [Sb:0] d;
    logic        [Sb:0] mag;
    d   = $signed({m[Sb-1], m}) + (Sb+1)'(256);
    mag = d[Sb] ? -d : d;
    return mag <= (Sb+1)'(tol);
  endfunction

  function automatic logic below_limit(med5pf_pkg::sample_t m,
                                       logic [med5pf_pkg::CenterLimitBits-1:0] lim);
    logic signed [Sb:0] e;
    logic        [Sb:0] mag;
    e   = $signed({m[Sb-1], m});
    mag = e[Sb] ? -e : e;
    return mag < (Sb+1)'(lim);
  endfunction

  // the whole pipe moves together whenever the output register can take data
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = head_valid_i && adv;

  for (genvar s = 0; s < WINDOW; s++) begin : g_layer
    if (s == 0) begin : g_first
      assign lay_in[s] = head_win_i;
    end else begin : g_rest
      assign lay_in[s] = sort_q[s-1];
    end

    // even layers compare pairs from slot 0, odd layers from slot 1
    always_comb begin
      lay_out[s] = lay_in[s];
      for (int a = 0; a < NumAxes; a++) begin
        for (int i = s % 2; i < WINDOW - 1; i += 2) begin
          if ($signed(lay_in[s][a][i]) < $signed(lay_in[s][a][i+1])) begin
            lay_out[s][a][i]   = lay_in[s][a][i+1];
            lay_out[s][a][i+1] = lay_in[s][a][i];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sort_q[s] <= lay_out[s];
        src_q[s]  <= (s == 0) ? head_src_i : src_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[WINDOW-2:0], head_valid_i};
      out_valid_q <= vld_q[WINDOW-1];
    end
  end

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      med[a] = sort_q[WINDOW-1][a][WINDOW/2];
    end
    all_missing = near_missing(med[0], missing_tol_i) && near_missing(med[1], missing_tol_i) &&
                  near_missing(med[2], missing_tol_i);
    centered    = below_limit(med[0], center_limit_i) && below_limit(med[1], center_limit_i);
    out_item_d.median_x      = med[0];
    out_item_d.median_y      = med[1];
    out_item_d.median_z      = med[2];
    out_item_d.chosen_source = src_q[WINDOW-1];
    priority if (all_missing) begin
      out_item_d.action = med5pf_pkg::ActClimb;
    end else if (centered) begin
      out_item_d.action = med5pf_pkg::ActDescend;
    end else begin
      out_item_d.action = med5pf_pkg::ActSideways;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

### hw/rtl/median5_position_filter_select_core.sv
// A request goes through the queue, the one-layer-per-stage sorter and output register.
// Throughput: one request per cycle while the output is not stalled, set by that sorter.
// A two-entry queue parts the front from the sorter; while a result waits the sorter
// holds and the queue still takes up to two requests. Reset clears control state and
// loads the register defaults; the first request after reset fills the window.
// ----------------------------------------------------------------------------
// median5_position_filter_select_core
// source selection and per-axis sliding median of target positions with
// action decision
// ----------------------------------------------------------------------------
`default_nettype none

module median5_position_filter_select_core #(
  parameter int WINDOW = med5pf_pkg::Window
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  med5pf_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output med5pf_pkg::out_item_t out_item_o,
  input  wire                   cfg_we_i,
  input  wire [0:0]             cfg_idx_i,
  input  wire [med5pf_pkg::CfgDataBits-1:0] cfg_wdata_i
);

  localparam int NumAxes   = med5pf_pkg::NumAxes;
  localparam int WinBits   = NumAxes * WINDOW * med5pf_pkg::SampleBits;
  localparam int EntryBits = WinBits + $bits(med5pf_pkg::source_e);

  logic [med5pf_pkg::CenterLimitBits-1:0] center_limit_q;
  logic [med5pf_pkg::MissingTolBits-1:0]  missing_tol_q;

  logic                push;
  logic                q_full;
  logic                q_valid;
  logic                pop;
  med5pf_pkg::source_e front_src;
  med5pf_pkg::source_e head_src;
  med5pf_pkg::sample_t [NumAxes-1:0][WINDOW-1:0] front_win;
  med5pf_pkg::sample_t [NumAxes-1:0][WINDOW-1:0] head_win;
  logic [EntryBits-1:0] q_wdata;
  logic [EntryBits-1:0] q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_limit_q <= med5pf_pkg::CenterLimitReset;
      missing_tol_q  <= med5pf_pkg::MissingTolReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        med5pf_pkg::CfgCenterLimit: begin
          center_limit_q <= cfg_wdata_i[med5pf_pkg::CenterLimitBits-1:0];
        end
        med5pf_pkg::CfgMissingTol: begin
          missing_tol_q <= cfg_wdata_i[med5pf_pkg::MissingTolBits-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  med5pf_front #(
    .WINDOW(WINDOW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .in_stall_o(in_stall_o),
    .push_o    (push),
    .win_o     (front_win),
    .source_o  (front_src)
  );

  assign q_wdata  = {front_src, front_win};
  assign head_src = med5pf_pkg::source_e'(q_rdata[EntryBits-1:WinBits]);
  assign head_win = q_rdata[WinBits-1:0];

  med5pf_queue #(
    .WIDTH(EntryBits),
    .DEPTH(med5pf_pkg::QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rdata_o(q_rdata)
  );

  med5pf_back #(
    .WINDOW(WINDOW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_valid),
    .head_win_i    (head_win),
    .head_src_i    (head_src),
    .pop_o         (pop),
    .center_limit_i(center_limit_q),
    .missing_tol_i (missing_tol_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

endmodule

`default_nettype wire

### hw/rtl/med5pf_checker.sv
// ----------------------------------------------------------------------------
// med5pf_checker
// port-level checks of the median position filter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module med5pf_checker (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   in_valid_i,
  input wire                   in_stall_o,
  input wire                   out_valid_o,
  input wire                   out_stall_i,
  input med5pf_pkg::out_item_t out_item_o
);

  logic [7:0] pend_q, pend_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // requests taken but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 8'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 8'd0)
    else $error("result without a pending request");

  a_climb_near_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.action == med5pf_pkg::ActClimb |->
      $signed(out_item_o.median_x) <= -1 && $signed(out_item_o.median_x) >= -511 &&
      $signed(out_item_o.median_y) <= -1 && $signed(out_item_o.median_y) >= -511 &&
      $signed(out_item_o.median_z) <= -1 && $signed(out_item_o.median_z) >= -511)
    else $error("climb with a median far from no detection");

endmodule

bind median5_position_filter_select_core med5pf_checker u_checker (.*);

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the five-tap median position filter: requests are
// driven through the valid/stall port, a local copy of the selection, window
// and action logic predicts every result, and each result is compared field
// by field; idling on both sides and register changes between phases
// ----------------------------------------------------------------------------

module tb_top;
  import med5pf_pkg::*;

  localparam int Depth     = Window - 1;
  localparam int IdleLimit = 2000;
  localparam int Drain     = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;
  logic                   cfg_we = 1'b0;
  logic [0:0]             cfg_idx = '0;
  logic [CfgDataBits-1:0] cfg_wdata = '0;

  // local copy of the block's registers and window
  logic [CenterLimitBits-1:0] center_limit_q = CenterLimitReset;
  logic [MissingTolBits-1:0]  missing_tol_q  = MissingTolReset;
  sample_t                    hist [NumAxes][Depth];
  bit                         primed = 1'b0;

  out_item_t expected_medians[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  median5_position_filter_select_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // ---------------------------------------------------------------- predictor
  function automatic sample_t slide_axis(int axis, sample_t s);
    sample_t w [Window];
    sample_t t;
    if (!primed) begin
      for (int i = 0; i < Depth; i++) hist[axis][i] = s;
    end
    for (int i = 0; i < Depth; i++) w[i] = hist[axis][i];
    w[Window-1] = s;
    for (int i = 0; i < Depth; i++) hist[axis][i] = w[i+1];
    // descending sort, middle element is the median
    for (int i = 0; i < Window; i++) begin
      for (int j = i + 1; j < Window; j++) begin
        if (w[i] < w[j]) begin
          t = w[i];
          w[i] = w[j];
          w[j] = t;
        end
      end
    end
    return w[Window/2];
  endfunction

  function automatic bit near_missing(sample_t m);
    int d;
    d = int'(m) - int'(Missing);
    if (d < 0) d = -d;
    return d <= int'(missing_tol_q);
  endfunction

  function automatic int magnitude(sample_t m);
    int v;
    v = int'(m);
    return (v < 0) ? -v : v;
  endfunction

  function automatic out_item_t predict_filter(in_item_t r);
    out_item_t o;
    bit        smart_none;
    bit        local_none;
    sample_t   cx, cy, cz;
    smart_none = (r.smart_x == Missing) && (r.smart_y == Missing) && (r.smart_z == Missing);
    local_none = (r.local_x == Missing) && (r.local_y == Missing) && (r.local_z == Missing);
    if (!smart_none) begin
      cx = r.smart_x; cy = r.smart_y; cz = r.smart_z;
      o.chosen_source = SrcSmart;
    end else begin
      cx = r.local_x; cy = r.local_y; cz = r.local_z;
      o.chosen_source = local_none ? SrcNone : SrcLocal;
    end
    o.median_x = slide_axis(0, cx);
    o.median_y = slide_axis(1, cy);
    o.median_z = slide_axis(2, cz);
    primed = 1'b1;
    if (near_missing(o.median_x) && near_missing(o.median_y) && near_missing(o.median_z))
      o.action = ActClimb;
    else if (magnitude(o.median_x) < int'(center_limit_q) &&
             magnitude(o.median_y) < int'(center_limit_q))
      o.action = ActDescend;
    else
      o.action = ActSideways;
    return o;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_request(input in_item_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item  <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    expected_medians.push_back(predict_filter(r));
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgCenterLimit) center_limit_q = data[CenterLimitBits-1:0];
    else missing_tol_q = data[MissingTolBits-1:0];
  endtask

  // drop valid, wait for all results, then let the pipe run empty
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------- checker
  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_medians.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = expected_medians.pop_front();
        check_field("median_x", int'(want.median_x), int'(out_item.median_x));
        check_field("median_y", int'(want.median_y), int'(out_item.median_y));
        check_field("median_z", int'(want.median_z), int'(out_item.median_z));
        check_field("action", int'(want.action), int'(out_item.action));
        check_field("chosen_source", int'(want.chosen_source), int'(out_item.chosen_source));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic in_item_t mk(sample_t sx, sample_t sy, sample_t sz,
                                  sample_t lx, sample_t ly, sample_t lz);
    in_item_t r;
    r.smart_x = sx; r.smart_y = sy; r.smart_z = sz;
    r.local_x = lx; r.local_y = ly; r.local_z = lz;
    return r;
  endfunction

  function automatic sample_t rand_span(int span);
    return sample_t'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic sample_t rand_full();
    return sample_t'($urandom);
  endfunction

  function automatic sample_t near_miss();
    return sample_t'(int'(Missing) + int'($urandom_range(12)) - 6);
  endfunction

  function automatic sample_t maybe_miss();
    return $urandom_range(1) ? Missing : rand_span(40000);
  endfunction

  function automatic in_item_t random_request(int kind);
    case (kind)
      1: return mk(Missing, Missing, Missing, rand_span(40000), rand_span(40000),
                   rand_span(40000));
      2: return mk(Missing, Missing, Missing, Missing, Missing, Missing);
      3: return mk(near_miss(), near_miss(), near_miss(), near_miss(), near_miss(),
                   near_miss());
      4: return mk(maybe_miss(), maybe_miss(), maybe_miss(), maybe_miss(), maybe_miss(),
                   maybe_miss());
      5: return mk(rand_full(), rand_full(), rand_full(), rand_full(), rand_full(),
                   rand_full());
      default: return mk(rand_span(40000), rand_span(40000), rand_span(40000),
                         rand_span(40000), rand_span(40000), rand_span(40000));
    endcase
  endfunction

  task automatic test_directed();
    sample_t mx;
    sample_t mn;
    mx = sample_t'(24'h7FFFFF);
    mn = sample_t'(24'h800000);
    // first request after reset fills the whole window
    send_request(mk(100, 200, 300, 7, 8, 9));
    send_request(mk(mx, mx, mx, mn, mn, mn));
    send_request(mk(mn, mn, mn, mx, mx, mx));
    // smart absent, local taken
    send_request(mk(Missing, Missing, Missing, 1, 2, 3));
    // nothing detected anywhere
    send_request(mk(Missing, Missing, Missing, Missing, Missing, Missing));
    // partly missing smart triple still counts as smart
    send_request(mk(Missing, Missing, 5, 11, 12, 13));
    send_request(mk(Missing, 5, Missing, 11, 12, 13));
    send_request(mk(5, Missing, Missing, Missing, Missing, Missing));
    send_request(mk(-4, 6, -8, Missing, Missing, Missing));
    // majority of no-detection gives climb
    repeat (5) send_request(mk(Missing, Missing, Missing, Missing, Missing, Missing));
    // tolerance edges around -1.0
    repeat (3) send_request(mk(-254, -258, -256, 0, 0, 0));
    repeat (3) send_request(mk(-253, -256, -256, 0, 0, 0));
    // centre limit edges
    repeat (3) send_request(mk(25599, -25599, 0, 0, 0, 0));
    repeat (3) send_request(mk(25600, 0, 0, 0, 0, 0));
    settle();
  endtask

  task automatic burst(int n);
    for (int i = 0; i < n; i++) send_request(random_request($urandom_range(5)));
  endtask

  task automatic test_register_extremes();
    write_reg(CfgCenterLimit, '0);
    write_reg(CfgMissingTol, '0);
    repeat (4) send_request(mk(Missing, Missing, Missing, Missing, Missing, Missing));
    repeat (3) send_request(mk(-255, -256, -256, 0, 0, 0));
    repeat (3) send_request(mk(0, 0, 0, 0, 0, 0));
    burst(10);
    settle();
    // upper bits of the tolerance write fall outside the register
    write_reg(CfgCenterLimit, 23'h7FFFFF);
    write_reg(CfgMissingTol, 23'h7FFFFF);
    repeat (3) send_request(mk(-1, -511, 0, 0, 0, 0));
    repeat (3) send_request(mk(-1, -512, -256, 0, 0, 0));
    repeat (3) send_request(mk(8388606, -8388607, 0, 0, 0, 0));
    burst(10);
    settle();
    write_reg(CfgCenterLimit, CenterLimitReset);
    write_reg(CfgMissingTol, MissingTolReset);
  endtask

  task automatic test_random_traffic(int count);
    int sent;
    int k;
    int kind;
    int run;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(19) == 0) begin
        // runs of absent targets so the medians settle on no detection
        run = $urandom_range(6, 3);
        kind = $urandom_range(1) ? 2 : 3;
        for (int i = 0; i < run; i++) send_request(random_request(kind));
        sent += run;
      end else begin
        k = $urandom_range(99);
        if (k < 45) kind = 0;
        else if (k < 60) kind = 1;
        else if (k < 70) kind = 2;
        else if (k < 78) kind = 3;
        else if (k < 85) kind = 4;
        else kind = 5;
        send_request(random_request(kind));
        sent++;
      end
    end
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 22;
    stall_pct     = 56;
    test_directed();
    test_register_extremes();
    test_random_traffic(600);

    send_idle_pct = 56;
    stall_pct     = 22;
    write_reg(CfgCenterLimit, 23'($urandom_range(60000, 1000)));
    write_reg(CfgMissingTol, 23'($urandom_range(255)));
    test_random_traffic(600);

    send_idle_pct = 0;
    stall_pct     = 0;
    write_reg(CfgCenterLimit, 23'($urandom_range(8388607)));
    write_reg(CfgMissingTol, 23'($urandom_range(40)));
    test_random_traffic(600);

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/med5pf_pkg.sv
hw/rtl/med5pf_front.sv
hw/rtl/med5pf_queue.sv
hw/rtl/med5pf_back.sv
hw/rtl/median5_position_filter_select_core.sv
hw/rtl/med5pf_checker.sv
test/tb_top.sv
